// ===== rtl/pafk_pkg.sv =====
`timescale 1ns / 1ps
// shared types, pipeline stage map and fixed-point constants for the
// planar arm forward kinematics core; no dependencies
package pafk_pkg;

    // pipeline stage map
    localparam int STEP_STAGES = 3;
    localparam int N_STEPS     = 6;
    localparam int ST_IN       = 0;
    localparam int ST_X        = 1;
    localparam int ST_X2       = 2;
    localparam int ST_STEP     = 3;
    localparam int ST_FINAL    = ST_STEP + STEP_STAGES * N_STEPS;
    localparam int ST_QUAD     = ST_FINAL + 1;
    localparam int ST_SUM      = ST_QUAD + 1;
    localparam int N_STG       = ST_SUM + 1;

    typedef logic [N_STG-1:0]       t_stage_en;
    typedef logic [STEP_STAGES-1:0] t_step_en;

    typedef logic signed [15:0] t_angle;
    typedef logic signed [15:0] t_pos;
    typedef logic signed [14:0] t_q13;
    typedef logic [30:0]        t_q30;
    typedef logic [31:0]        t_w32;

    typedef struct packed {
        t_angle joint_angle_a;
        t_angle joint_angle_b;
        t_angle joint_angle_c;
    } t_joint;

    typedef struct packed {
        t_pos   pos_x;
        t_pos   pos_y;
        t_angle heading;
    } t_pose;

    localparam t_w32        Q30_ONE    = 32'h4000_0000;
    localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
    localparam logic [47:0] X_ROUND    = 48'd32768;
    localparam logic [32:0] Q13_ROUND  = 33'd65536;

    // horner divisors and their 2^32 reciprocals
    localparam logic [7:0] C_SIN_DIV [N_STEPS] = '{
        8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
    };
    localparam logic [7:0] C_COS_DIV [N_STEPS] = '{
        8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
    };
    localparam t_w32 C_SIN_RECIP [N_STEPS] = '{
        32'((64'd1 << 32) / 64'd156), 32'((64'd1 << 32) / 64'd110),
        32'((64'd1 << 32) / 64'd72),  32'((64'd1 << 32) / 64'd42),
        32'((64'd1 << 32) / 64'd20),  32'((64'd1 << 32) / 64'd6)
    };
    localparam t_w32 C_COS_RECIP [N_STEPS] = '{
        32'((64'd1 << 32) / 64'd132), 32'((64'd1 << 32) / 64'd90),
        32'((64'd1 << 32) / 64'd56),  32'((64'd1 << 32) / 64'd30),
        32'((64'd1 << 32) / 64'd12),  32'((64'd1 << 32) / 64'd2)
    };

endpackage

// ===== rtl/pafk_joint_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel carrying the three joint angles
// depends on pafk_pkg
interface pafk_joint_if;
    import pafk_pkg::*;

    logic   valid;
    logic   ready;
    t_joint data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pafk_pose_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel carrying the end-effector pose
// depends on pafk_pkg
interface pafk_pose_if;
    import pafk_pkg::*;

    logic  valid;
    logic  ready;
    t_pose data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/planar_arm_forward_kinematics_core.sv =====
`timescale 1ns / 1ps
// top level: planar three-link arm forward kinematics, fully pipelined
// depends on pafk_pkg, pafk_joint_if, pafk_pose_if, pafk_trig, pafk_horner_step
//
//  channel   dir  fields                                        beat
//  i_joint   in   joint_angle_a, joint_angle_b, joint_angle_c   valid & ready
//  o_pose    out  pos_x, pos_y, heading                         valid & ready
//
// one beat per cycle without a stall; stages in order: joint sums,
// scaling, square, six three-register horner steps, final, quadrant, link sum
// each stage holds a valid bit and moves when the stage after it is empty or
// moving, so bubbles close up and input is taken while a result waits
// the output stage is the last pipeline register; a stall holds each beat with no empty stage after it
// synchronous active-low reset clears the valid bits only
module planar_arm_forward_kinematics_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pafk_joint_if.sink  i_joint,
    pafk_pose_if.source o_pose
);
    import pafk_pkg::*;

    t_stage_en w_en;
    t_stage_en n_v;
    t_stage_en w_shift;
    t_q13      w_sin [3];
    t_q13      w_cos [3];
    t_angle    w_h   [3];
    t_pos      w_sx;
    t_pos      w_cy;
    logic      w_in_acc;
    logic      w_out_acc;

    t_stage_en r_v;
    t_angle    r_h  [3];
    t_angle    r_hd [ST_X:ST_QUAD];
    t_pose     r_pose;

    for (genvar s = 0; s < N_STG; s++) begin : g_en
        assign w_en[s] = o_pose.ready || !(&r_v[N_STG-1:s]);
    end

    assign w_shift = {r_v[N_STG-2:0], i_joint.valid};
    assign n_v     = (w_en & w_shift) | (~w_en & r_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign w_h[0] = i_joint.data.joint_angle_a;
    assign w_h[1] = i_joint.data.joint_angle_a + i_joint.data.joint_angle_b;
    assign w_h[2] = w_h[1] + i_joint.data.joint_angle_c;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_IN]) begin
            r_h <= w_h;
        end
    end

    for (genvar s = ST_X; s <= ST_QUAD; s++) begin : g_head
        if (s == ST_X) begin : g_first
            always_ff @(posedge i_clk) begin
                if (w_en[s]) begin
                    r_hd[s] <= r_h[2];
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (w_en[s]) begin
                    r_hd[s] <= r_hd[s-1];
                end
            end
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_link
        pafk_trig u_trig (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_angle (r_h[j]),
            .o_sin   (w_sin[j]),
            .o_cos   (w_cos[j])
        );
    end

    assign w_sx = 16'(w_sin[0]) + 16'(w_sin[1]) + 16'(w_sin[2]);
    assign w_cy = 16'(w_cos[0]) + 16'(w_cos[1]) + 16'(w_cos[2]);

    always_ff @(posedge i_clk) begin
        if (w_en[ST_SUM]) begin
            r_pose.pos_x   <= -w_sx;
            r_pose.pos_y   <= w_cy;
            r_pose.heading <= r_hd[ST_QUAD];
        end
    end

    assign i_joint.ready = w_en[ST_IN];
    assign o_pose.valid  = r_v[ST_SUM];
    assign o_pose.data   = r_pose;

    assign w_in_acc  = i_joint.valid & i_joint.ready;
    assign w_out_acc = o_pose.valid & o_pose.ready;

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_v) && !o_pose.ready) |-> !i_joint.ready)
        else $error("input taken while pipeline full and output stalled");

    a_bubble_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(&r_v) |-> i_joint.ready)
        else $error("input refused while a pipeline stage is empty");

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ($countones(r_v) == $past($countones(r_v))
            + int'($past(w_in_acc)) - int'($past(w_out_acc))))
        else $error("pipeline occupancy does not match accepted beats");
endmodule

// ===== rtl/pafk_horner_step.sv =====
`timescale 1ns / 1ps
// one horner step t' = 1 - (x2 * t) / k in q30, three register stages:
// multiply, reciprocal multiply, remainder correction; depends on pafk_pkg
module pafk_horner_step (
    input  logic               i_clk,
    input  pafk_pkg::t_step_en i_en,
    input  logic [7:0]         i_divisor,
    input  pafk_pkg::t_w32     i_recip,
    input  pafk_pkg::t_w32     i_x2,
    input  pafk_pkg::t_w32     i_q,
    output pafk_pkg::t_w32     o_q
);
    import pafk_pkg::*;

    localparam int SA = 0;
    localparam int SB = 1;
    localparam int SC = 2;

    t_w32        w_diff;
    t_q30        w_t;
    logic [62:0] w_prod;
    logic [63:0] w_rprod;
    logic [39:0] w_qk;
    logic [39:0] w_rem;
    logic        w_fix;

    t_w32 r_va;
    t_w32 r_vb;
    t_w32 r_q0;
    t_w32 r_q;

    assign w_diff  = Q30_ONE - i_q;
    assign w_t     = w_diff[30:0];
    assign w_prod  = 63'(i_x2) * 63'(w_t);
    assign w_rprod = 64'(r_va) * 64'(i_recip);
    assign w_qk    = 40'(r_q0) * 40'(i_divisor);
    assign w_rem   = 40'(r_vb) - w_qk;
    assign w_fix   = (w_rem >= 40'(i_divisor));

    always_ff @(posedge i_clk) begin
        if (i_en[SA]) begin
            r_va <= w_prod[61:30];
        end
        if (i_en[SB]) begin
            r_vb <= r_va;
            r_q0 <= w_rprod[63:32];
        end
        if (i_en[SC]) begin
            r_q <= r_q0 + 32'(w_fix);
        end
    end

    assign o_q = r_q;
endmodule

// ===== rtl/pafk_trig.sv =====
`timescale 1ns / 1ps
// pipelined q13 sine and cosine of a binary angle: radian scaling, square,
// two horner chains, rounding and quadrant fold; depends on pafk_pkg
module pafk_trig (
    input  logic                i_clk,
    input  pafk_pkg::t_stage_en i_en,
    input  pafk_pkg::t_angle    i_angle,
    output pafk_pkg::t_q13      o_sin,
    output pafk_pkg::t_q13      o_cos
);
    import pafk_pkg::*;

    localparam logic [1:0] QD_FIRST  = 2'd0;
    localparam logic [1:0] QD_SECOND = 2'd1;
    localparam logic [1:0] QD_THIRD  = 2'd2;
    localparam logic [1:0] QD_FOURTH = 2'd3;
    localparam int X2_LAST = ST_STEP + STEP_STAGES * (N_STEPS - 1) - 1;

    logic [47:0] w_xprod;
    t_q30        w_x;
    logic [61:0] w_sq;
    t_w32        w_sin_q [N_STEPS+1];
    t_w32        w_cos_q [N_STEPS+1];
    t_w32        w_sin_d;
    t_q30        w_sin_t;
    logic [61:0] w_sin_prod;
    t_w32        w_cos_p;
    logic [32:0] w_sin_rnd;
    logic [32:0] w_cos_rnd;
    t_q13        w_sv;
    t_q13        w_cv;
    t_q13        n_sin;
    t_q13        n_cos;

    t_q30       r_xp  [ST_X:ST_FINAL-1];
    logic [1:0] r_qd  [ST_X:ST_FINAL];
    t_w32       r_x2p [ST_X2:X2_LAST];
    t_w32       r_sin30;
    t_w32       r_cos30;
    t_q13       r_sin;
    t_q13       r_cos;

    assign w_xprod = 48'(i_angle[13:0]) * 48'(TWO_PI_Q30) + X_ROUND;
    assign w_x     = w_xprod[46:16];
    assign w_sq    = 62'(r_xp[ST_X]) * 62'(r_xp[ST_X]);

    for (genvar s = ST_X; s < ST_FINAL; s++) begin : g_x
        if (s == ST_X) begin : g_head
            always_ff @(posedge i_clk) begin
                if (i_en[s]) begin
                    r_xp[s] <= w_x;
                end
            end
        end else begin : g_tail
            always_ff @(posedge i_clk) begin
                if (i_en[s]) begin
                    r_xp[s] <= r_xp[s-1];
                end
            end
        end
    end

    for (genvar s = ST_X; s <= ST_FINAL; s++) begin : g_quad
        if (s == ST_X) begin : g_head
            always_ff @(posedge i_clk) begin
                if (i_en[s]) begin
                    r_qd[s] <= i_angle[15:14];
                end
            end
        end else begin : g_tail
            always_ff @(posedge i_clk) begin
                if (i_en[s]) begin
                    r_qd[s] <= r_qd[s-1];
                end
            end
        end
    end

    for (genvar s = ST_X2; s <= X2_LAST; s++) begin : g_x2
        if (s == ST_X2) begin : g_head
            always_ff @(posedge i_clk) begin
                if (i_en[s]) begin
                    r_x2p[s] <= w_sq[61:30];
                end
            end
        end else begin : g_tail
            always_ff @(posedge i_clk) begin
                if (i_en[s]) begin
                    r_x2p[s] <= r_x2p[s-1];
                end
            end
        end
    end

    assign w_sin_q[0] = '0;
    assign w_cos_q[0] = '0;

    for (genvar j = 0; j < N_STEPS; j++) begin : g_step
        pafk_horner_step u_sin_step (
            .i_clk     (i_clk),
            .i_en      (i_en[ST_STEP + STEP_STAGES * j +: STEP_STAGES]),
            .i_divisor (C_SIN_DIV[j]),
            .i_recip   (C_SIN_RECIP[j]),
            .i_x2      (r_x2p[ST_STEP + STEP_STAGES * j - 1]),
            .i_q       (w_sin_q[j]),
            .o_q       (w_sin_q[j+1])
        );
        pafk_horner_step u_cos_step (
            .i_clk     (i_clk),
            .i_en      (i_en[ST_STEP + STEP_STAGES * j +: STEP_STAGES]),
            .i_divisor (C_COS_DIV[j]),
            .i_recip   (C_COS_RECIP[j]),
            .i_x2      (r_x2p[ST_STEP + STEP_STAGES * j - 1]),
            .i_q       (w_cos_q[j]),
            .o_q       (w_cos_q[j+1])
        );
    end

    assign w_sin_d    = Q30_ONE - w_sin_q[N_STEPS];
    assign w_sin_t    = w_sin_d[30:0];
    assign w_sin_prod = 62'(r_xp[ST_FINAL-1]) * 62'(w_sin_t);
    assign w_cos_p    = w_cos_q[N_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en[ST_FINAL]) begin
            r_sin30 <= w_sin_prod[61:30];
            r_cos30 <= (w_cos_p > Q30_ONE) ? '0 : (Q30_ONE - w_cos_p);
        end
    end

    assign w_sin_rnd = 33'(r_sin30) + Q13_ROUND;
    assign w_cos_rnd = 33'(r_cos30) + Q13_ROUND;
    assign w_sv      = t_q13'({1'b0, w_sin_rnd[30:17]});
    assign w_cv      = t_q13'({1'b0, w_cos_rnd[30:17]});

    always_comb begin
        case (r_qd[ST_FINAL])
            QD_FIRST: begin
                n_sin = w_sv;
                n_cos = w_cv;
            end
            QD_SECOND: begin
                n_sin = w_cv;
                n_cos = -w_sv;
            end
            QD_THIRD: begin
                n_sin = -w_sv;
                n_cos = -w_cv;
            end
            QD_FOURTH: begin
                n_sin = -w_cv;
                n_cos = w_sv;
            end
            default: begin
                n_sin = w_sv;
                n_cos = w_cv;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_QUAD]) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;
endmodule

// ===== verif/pafk_pose_checker.sv =====
`timescale 1ns / 1ps
// pose checker: watches the joint and pose channels, predicts each pose from the joint angles
// and compares it field by field; depends on pafk_pkg, pafk_joint_if and pafk_pose_if
module pafk_pose_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pafk_joint_if i_joint,
    pafk_pose_if  i_pose,
    output int    o_mismatches,
    output int    o_poses_pending,
    output int    o_poses_checked
);
    import pafk_pkg::*;

    localparam longint unsigned Q30_UNIT    = 64'd1 << 30;
    localparam longint unsigned TURN_Q30    = 64'd6746518852;

    typedef enum logic [1:0] {
        QUAD_FIRST,
        QUAD_SECOND,
        QUAD_THIRD,
        QUAD_FOURTH
    } t_quadrant;

    t_pose expected_poses [$];
    int    mismatches = 0;
    int    checked    = 0;

    function automatic longint unsigned horner_stage(longint unsigned x2, longint unsigned t,
                                                     longint unsigned divisor);
        return Q30_UNIT - ((x2 * t) >> 30) / divisor;
    endfunction

    function automatic int q30_to_q13(longint unsigned v);
        return int'((v + (64'd1 << 16)) >> 17);
    endfunction

    // q13 sine and cosine of a binary angle
    function automatic void angle_sin_cos(input logic [15:0] ang, output int s, output int c);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned p;
        longint unsigned residue;
        int              sv;
        int              cv;
        residue = longint'(ang[13:0]);
        x  = (residue * TURN_Q30 + 64'd32768) >> 16;
        x2 = (x * x) >> 30;
        t = horner_stage(x2, Q30_UNIT, 156);
        t = horner_stage(x2, t, 110);
        t = horner_stage(x2, t, 72);
        t = horner_stage(x2, t, 42);
        t = horner_stage(x2, t, 20);
        t = horner_stage(x2, t, 6);
        sv = q30_to_q13((x * t) >> 30);
        t = horner_stage(x2, Q30_UNIT, 132);
        t = horner_stage(x2, t, 90);
        t = horner_stage(x2, t, 56);
        t = horner_stage(x2, t, 30);
        t = horner_stage(x2, t, 12);
        p = ((x2 * t) >> 30) / 2;
        // cosine clipped at zero near the quarter turn
        cv = q30_to_q13((p > Q30_UNIT) ? 64'd0 : (Q30_UNIT - p));
        case (t_quadrant'(ang[15:14]))
            QUAD_FIRST: begin
                s = sv;
                c = cv;
            end
            QUAD_SECOND: begin
                s = cv;
                c = -sv;
            end
            QUAD_THIRD: begin
                s = -sv;
                c = -cv;
            end
            default: begin
                s = -cv;
                c = sv;
            end
        endcase
    endfunction

    function automatic t_pose arm_pose(t_joint j);
        logic [15:0] heading;
        logic [15:0] joints [3];
        int          px;
        int          py;
        int          s;
        int          c;
        t_pose       pose;
        joints[0] = j.joint_angle_a;
        joints[1] = j.joint_angle_b;
        joints[2] = j.joint_angle_c;
        heading = 16'd0;
        px = 0;
        py = 0;
        for (int k = 0; k < 3; k++) begin
            heading = heading + joints[k];
            angle_sin_cos(heading, s, c);
            px = px - s;
            py = py + c;
        end
        pose.pos_x   = t_pos'(px[15:0]);
        pose.pos_y   = t_pos'(py[15:0]);
        pose.heading = t_angle'(heading);
        return pose;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name,
                     $signed(want), $signed(got));
        end
    endtask

    always @(posedge i_clk) begin
        t_pose want;
        if (i_rst_n) begin
            if (i_pose.valid && i_pose.ready) begin
                if (expected_poses.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected pose, expected none actual x %0d y %0d h %0d",
                             $time, i_pose.data.pos_x, i_pose.data.pos_y,
                             i_pose.data.heading);
                end else begin
                    want = expected_poses.pop_front();
                    check_field("pos_x", want.pos_x, i_pose.data.pos_x);
                    check_field("pos_y", want.pos_y, i_pose.data.pos_y);
                    check_field("heading", want.heading, i_pose.data.heading);
                    checked++;
                end
            end
            if (i_joint.valid && i_joint.ready) begin
                expected_poses.push_back(arm_pose(i_joint.data));
            end
        end
        o_mismatches    <= mismatches;
        o_poses_pending <= expected_poses.size();
        o_poses_checked <= checked;
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// top of the forward kinematics testbench: clock, reset, joint stimulus, pose back-pressure
// and verdict; depends on pafk_pkg, the channel interfaces, the core and pafk_pose_checker
module testbench;
    import pafk_pkg::*;

    localparam int RANDOM_PER_PHASE = 100;
    localparam int PRESSURE_ITEMS   = 40;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES     = 40;
    localparam int CYCLE_LIMIT      = 200000;

    logic clk;
    logic rst_n;
    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    int   holds_asked        = 0;
    int   holds_done         = 0;
    int   joints_sent        = 0;
    int   mismatches;
    int   poses_pending;
    int   poses_checked;

    pafk_joint_if joint_ch ();
    pafk_pose_if  pose_ch ();

    planar_arm_forward_kinematics_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_joint (joint_ch),
        .o_pose  (pose_ch)
    );

    pafk_pose_checker pose_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_joint         (joint_ch),
        .i_pose          (pose_ch),
        .o_mismatches    (mismatches),
        .o_poses_pending (poses_pending),
        .o_poses_checked (poses_checked)
    );

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic t_joint make_joint(t_angle a, t_angle b, t_angle c);
        t_joint j;
        j.joint_angle_a = a;
        j.joint_angle_b = b;
        j.joint_angle_c = c;
        return j;
    endfunction

    function automatic t_angle random_angle();
        logic [1:0] quad;
        quad = 2'($urandom_range(3));
        case ($urandom_range(3))
            0: begin
                // near a quadrant boundary
                return t_angle'({quad, 14'd0} + 16'($urandom_range(8)) - 16'd4);
            end
            1: begin
                case ($urandom_range(4))
                    0:       return 16'h0000;
                    1:       return 16'h8000;
                    2:       return 16'h7FFF;
                    3:       return 16'hFFFF;
                    default: return 16'h3FFF;
                endcase
            end
            default: return t_angle'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic t_joint random_joint();
        t_joint j;
        j = make_joint(random_angle(), random_angle(), random_angle());
        // force a half-turn heading now and then
        if ($urandom_range(9) == 0) begin
            j.joint_angle_c = t_angle'(16'h8000 - j.joint_angle_a - j.joint_angle_b);
        end
        return j;
    endfunction

    task automatic send_joint(input t_joint j);
        while ($urandom_range(99) < sender_idle_pct) begin
            joint_ch.valid <= 1'b0;
            @(posedge clk);
        end
        joint_ch.valid <= 1'b1;
        joint_ch.data  <= j;
        do begin
            @(posedge clk);
        end while (!joint_ch.ready);
        joints_sent++;
    endtask

    task automatic wait_drained();
        joint_ch.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (poses_pending != 0) begin
            @(posedge clk);
        end
    endtask

    // pose back-pressure, with a long hold-off on request
    initial begin
        forever begin
            if (holds_done != holds_asked) begin
                holds_done++;
                pose_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end else begin
                pose_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
                @(posedge clk);
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    initial begin
        t_joint directed [$];
        int     idle_of [4];
        int     stall_of [4];
        idle_of  = '{0, 71, 0, 17};
        stall_of = '{0, 0, 71, 17};
        rst_n          <= 1'b0;
        joint_ch.valid <= 1'b0;
        joint_ch.data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        directed.push_back(make_joint(16'h0000, 16'h0000, 16'h0000));
        directed.push_back(make_joint(16'h7FFF, 16'h7FFF, 16'h7FFF));
        directed.push_back(make_joint(16'h8000, 16'h8000, 16'h8000));
        directed.push_back(make_joint(16'h8000, 16'h0000, 16'h0000));
        directed.push_back(make_joint(16'h0000, 16'h8000, 16'h0000));
        directed.push_back(make_joint(16'h4000, 16'h4000, 16'h0000));
        directed.push_back(make_joint(16'hC000, 16'hC000, 16'h0000));
        directed.push_back(make_joint(16'h2000, 16'h2000, 16'h4000));
        directed.push_back(make_joint(16'h7FFF, 16'h0001, 16'h0000));
        directed.push_back(make_joint(16'h4000, 16'h0000, 16'h0000));
        directed.push_back(make_joint(16'hC000, 16'h0000, 16'h0000));
        directed.push_back(make_joint(16'h3FFF, 16'h0001, 16'h3FFF));
        directed.push_back(make_joint(16'h3FFF, 16'h3FFF, 16'h3FFF));
        directed.push_back(make_joint(16'hFFFF, 16'hFFFF, 16'hFFFF));
        directed.push_back(make_joint(16'h0001, 16'h0001, 16'h0001));
        directed.push_back(make_joint(16'h5555, 16'hAAAA, 16'h5555));
        directed.push_back(make_joint(16'hAAAA, 16'h5555, 16'hAAAA));
        directed.push_back(make_joint(16'h8001, 16'h7FFF, 16'h8000));
        foreach (directed[k]) begin
            send_joint(directed[k]);
        end
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct    = idle_of[phase];
            receiver_stall_pct = stall_of[phase];
            if (phase == 0) begin
                // output held off while joints keep coming
                holds_asked++;
                repeat (PRESSURE_ITEMS) send_joint(random_joint());
            end
            repeat (RANDOM_PER_PHASE / 2) send_joint(random_joint());
            if (phase == 1) begin
                wait_drained();
            end
            repeat (RANDOM_PER_PHASE / 2) send_joint(random_joint());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("summary: %0d joint beats sent, %0d poses checked, %0d mismatches",
                 joints_sent, poses_checked, mismatches);
        $display("summary: phases without idling, with sender gaps, output stalls, both, "
                 , "a long output hold-off and full drains");
        if (mismatches == 0 && poses_pending == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
